/* sv/tpag_pkg.sv */
// shared types and constants of the tile page address generator
// register map, sample formats, controller states, command and status words
// no dependencies
package tpag_pkg;

  // default limits of the traversal
  localparam int MAX_DIM_DEF      = 16384;
  localparam int MAX_TILE_DEF     = 1024;
  localparam int MAX_BORDER_DEF   = 64;
  localparam int MAX_CHANNELS_DEF = 4;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  // result field widths
  localparam int SRC_IDX_W   = 30;
  localparam int PAGE_ELEM_W = 23;
  localparam int PAGE_BYTE_W = 25;
  localparam int TILE_NUM_W  = 28;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_TILE_SIZE     = 3'd2,
    REG_BORDER_SIZE   = 3'd3,
    REG_CHANNEL_COUNT = 3'd4,
    REG_SAMPLE_FORMAT = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_U16 = 2'd1,
    FMT_F32 = 2'd2
  } sample_fmt_e;

  typedef struct packed {
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic [10:0] tile_size;
    logic [6:0]  border_size;
    logic [2:0]  channel_count;
    logic [1:0]  sample_format;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic fetch;   // latch coordinates and advance the position counters
    logic mul;     // row times width product
    logic emit;    // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finished;  // traversal done, idle until restart
    logic out_free;  // output register can take a word this cycle
  } sts_t;

endpackage

/* sv/tpag_cfg_regs.sv */
// configuration registers of the tile page address generator
// depends on tpag_pkg
module tpag_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tpag_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output tpag_pkg::cfg_t                   cfg_o
);

  tpag_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tpag_pkg::cfg_reg_e'(cfg_addr_i))
        tpag_pkg::REG_IMAGE_WIDTH:   cfg_d.image_width   = cfg_wdata_i[14:0];
        tpag_pkg::REG_IMAGE_HEIGHT:  cfg_d.image_height  = cfg_wdata_i[14:0];
        tpag_pkg::REG_TILE_SIZE:     cfg_d.tile_size     = cfg_wdata_i[10:0];
        tpag_pkg::REG_BORDER_SIZE:   cfg_d.border_size   = cfg_wdata_i[6:0];
        tpag_pkg::REG_CHANNEL_COUNT: cfg_d.channel_count = cfg_wdata_i[2:0];
        tpag_pkg::REG_SAMPLE_FORMAT: cfg_d.sample_format = cfg_wdata_i[1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= 15'd1;
      cfg_q.image_height  <= 15'd1;
      cfg_q.tile_size     <= 11'd1;
      cfg_q.border_size   <= 7'd0;
      cfg_q.channel_count <= 3'd1;
      cfg_q.sample_format <= 2'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/tpag_ctrl.sv */
// sequencing controller of the tile page address generator
// fetch, multiply and emit steps per word; depends on tpag_pkg
module tpag_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tpag_pkg::sts_t  sts_i,
  output tpag_pkg::cmd_t  cmd_o
);

  tpag_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpag_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      tpag_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = tpag_pkg::ST_FETCH;
        end
      end
      tpag_pkg::ST_FETCH: begin
        if (sts_i.finished) begin
          state_d = tpag_pkg::ST_IDLE;  // no element for this word
        end else begin
          cmd_o.fetch = 1'b1;
          state_d     = tpag_pkg::ST_MUL;
        end
      end
      tpag_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = tpag_pkg::ST_EMIT;
      end
      tpag_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            state_d      = tpag_pkg::ST_FETCH;
          end else begin
            state_d = tpag_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = tpag_pkg::ST_IDLE;
    endcase
  end

endmodule

/* sv/tpag_datapath.sv */
// datapath of the tile page address generator
// position counters, clamping, index multiply and output register; depends on tpag_pkg
module tpag_datapath #(
  parameter int MAX_DIM      = tpag_pkg::MAX_DIM_DEF,
  parameter int MAX_TILE     = tpag_pkg::MAX_TILE_DEF,
  parameter int MAX_BORDER   = tpag_pkg::MAX_BORDER_DEF,
  parameter int MAX_CHANNELS = tpag_pkg::MAX_CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tpag_pkg::cfg_t                     cfg_i,
  input  tpag_pkg::cmd_t                     cmd_i,
  output tpag_pkg::sts_t                     sts_o,
  input  logic                               restart_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [tpag_pkg::SRC_IDX_W-1:0]     source_index_o,
  output logic [tpag_pkg::PAGE_ELEM_W-1:0]   page_element_o,
  output logic [tpag_pkg::PAGE_BYTE_W-1:0]   page_byte_offset_o,
  output logic [tpag_pkg::TILE_NUM_W-1:0]    tile_number_o,
  output logic                               last_in_tile_o,
  output logic                               last_in_image_o
);

  localparam int SIW = tpag_pkg::SRC_IDX_W;
  localparam int PEW = tpag_pkg::PAGE_ELEM_W;
  localparam int PBW = tpag_pkg::PAGE_BYTE_W;
  localparam int TNW = tpag_pkg::TILE_NUM_W;
  // clamped image dimension, origin / source coordinate
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int OW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int TW  = $clog2(MAX_TILE + 1);
  localparam int BW  = (MAX_BORDER > 0) ? $clog2(MAX_BORDER + 1) : 1;
  localparam int PW  = $clog2(MAX_TILE + 2 * MAX_BORDER + 1);
  localparam int CHW = $clog2(MAX_CHANNELS + 1);
  localparam int CCW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  // common width of the position compares
  localparam int AW  = ((DW > PW) ? DW : PW) + 1;

  function automatic logic [AW-1:0] tile_extent(input logic [AW-1:0] org,
                                                input logic [AW-1:0] dim,
                                                input logic [AW-1:0] tsz);
    logic [AW-1:0] rem;
    rem = dim - org;
    if (org >= dim) return AW'(1);
    return (rem < tsz) ? rem : tsz;
  endfunction

  function automatic logic [AW-1:0] clamp_coord(input logic [AW-1:0] s,
                                                input logic [AW-1:0] b,
                                                input logic [AW-1:0] dim);
    logic [AW-1:0] t;
    t = s - b;
    if (s < b) return '0;
    return (t > dim - AW'(1)) ? dim - AW'(1) : t;
  endfunction

  // limited register values
  logic [DW-1:0]  w, h;
  logic [TW-1:0]  ts;
  logic [BW-1:0]  bs;
  logic [CHW-1:0] nc;

  always_comb begin
    w  = (cfg_i.image_width == '0) ? DW'(1) :
         (32'(cfg_i.image_width) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg_i.image_width);
    h  = (cfg_i.image_height == '0) ? DW'(1) :
         (32'(cfg_i.image_height) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg_i.image_height);
    ts = (cfg_i.tile_size == '0) ? TW'(1) :
         (32'(cfg_i.tile_size) > MAX_TILE) ? TW'(MAX_TILE) : TW'(cfg_i.tile_size);
    bs = (32'(cfg_i.border_size) > MAX_BORDER) ? BW'(MAX_BORDER) : BW'(cfg_i.border_size);
    nc = (cfg_i.channel_count == '0) ? CHW'(1) :
         (32'(cfg_i.channel_count) > MAX_CHANNELS) ? CHW'(MAX_CHANNELS) :
                                                     CHW'(cfg_i.channel_count);
  end

  // traversal position
  logic [OW-1:0]  ox_q, ox_d, oy_q, oy_d;
  logic [PW-1:0]  px_q, px_d, py_q, py_d;
  logic [CCW-1:0] ch_q, ch_d;
  logic [TNW-1:0] tile_q, tile_d;
  logic [PEW-1:0] pec_q, pec_d;
  logic           finished_q, finished_d;

  // fetch stage
  logic [OW-1:0]  sx_q, sy_q;
  logic [CCW-1:0] chs_q;
  logic [PEW-1:0] pecs_q;
  logic [TNW-1:0] tiles_q;
  logic           lt_q, li_q;
  // multiply stage
  logic [OW+DW-1:0] prod_q;

  logic [AW-1:0] aw, ah, ats, abd, aox, aoy, pgw, pgh, nx_ox, nx_oy;
  logic [AW-1:0] sx_full, sy_full;
  logic          end_c, end_x, end_y, more_x, more_y, last_tile;

  always_comb begin
    aw    = AW'(w);
    ah    = AW'(h);
    ats   = AW'(ts);
    abd   = AW'(bs);
    aox   = AW'(ox_q);
    aoy   = AW'(oy_q);
    pgw   = tile_extent(aox, aw, ats) + (abd << 1);
    pgh   = tile_extent(aoy, ah, ats) + (abd << 1);
    sx_full = clamp_coord(aox + AW'(px_q), abd, aw);
    sy_full = clamp_coord(aoy + AW'(py_q), abd, ah);
    nx_ox = aox + ats;
    nx_oy = aoy + ats;
    end_c = (AW'(ch_q) + AW'(1)) >= AW'(nc);
    end_x = (AW'(px_q) + AW'(1)) >= pgw;
    end_y = (AW'(py_q) + AW'(1)) >= pgh;
    more_x = nx_ox < aw;
    more_y = nx_oy < ah;
    last_tile = !more_x && !more_y;
  end

  // next position, channel fastest then column, row and tile
  always_comb begin
    ox_d = ox_q; oy_d = oy_q; px_d = px_q; py_d = py_q;
    ch_d = ch_q; tile_d = tile_q; pec_d = pec_q; finished_d = finished_q;
    if (cmd_i.accept && restart_i) begin
      ox_d = '0; oy_d = '0; px_d = '0; py_d = '0;
      ch_d = '0; tile_d = '0; pec_d = '0; finished_d = 1'b0;
    end else if (cmd_i.fetch) begin
      pec_d = pec_q + PEW'(1);
      if (!end_c) begin
        ch_d = ch_q + CCW'(1);
      end else begin
        ch_d = '0;
        if (!end_x) begin
          px_d = px_q + PW'(1);
        end else begin
          px_d = '0;
          if (!end_y) begin
            py_d = py_q + PW'(1);
          end else begin
            py_d   = '0;
            pec_d  = '0;
            tile_d = tile_q + TNW'(1);
            if (more_x) begin
              ox_d = OW'(nx_ox);
            end else begin
              ox_d = '0;
              if (more_y) begin
                oy_d = OW'(nx_oy);
              end else begin
                oy_d       = '0;
                finished_d = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q       <= '0;
      oy_q       <= '0;
      px_q       <= '0;
      py_q       <= '0;
      ch_q       <= '0;
      tile_q     <= '0;
      pec_q      <= '0;
      finished_q <= 1'b1;
    end else begin
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      px_q       <= px_d;
      py_q       <= py_d;
      ch_q       <= ch_d;
      tile_q     <= tile_d;
      pec_q      <= pec_d;
      finished_q <= finished_d;
    end
  end

  // stage registers, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      sx_q    <= OW'(sx_full);
      sy_q    <= OW'(sy_full);
      chs_q   <= ch_q;
      pecs_q  <= pec_q;
      tiles_q <= tile_q;
      lt_q    <= end_c && end_x && end_y;
      li_q    <= end_c && end_x && end_y && last_tile;
    end
    if (cmd_i.mul) begin
      prod_q <= (OW+DW)'(sy_q) * (OW+DW)'(w);
    end
  end

  // emit: (row * width + column) * channels + channel, wraps in the field width
  logic [SIW-1:0] src_d;
  logic [PBW-1:0] byte_d;

  always_comb begin
    src_d = (SIW'(prod_q) + SIW'(sx_q)) * SIW'(nc) + SIW'(chs_q);
    case (tpag_pkg::sample_fmt_e'(cfg_i.sample_format))
      tpag_pkg::FMT_U8:  byte_d = PBW'(pecs_q);
      tpag_pkg::FMT_U16: byte_d = PBW'({pecs_q, 1'b0});
      default:           byte_d = PBW'({pecs_q, 2'b00});  // float and the unused code
    endcase
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      source_index_o     <= src_d;
      page_element_o     <= pecs_q;
      page_byte_offset_o <= byte_d;
      tile_number_o      <= tiles_q;
      last_in_tile_o     <= lt_q;
      last_in_image_o    <= li_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.finished  = finished_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

/* sv/tile_page_address_generator.sv */
// top level of the tile page address generator
// joins tpag_cfg_regs, tpag_ctrl and tpag_datapath; depends on tpag_pkg
//
// Walks an image tile by tile, row-major, and gives one element per input word:
// channel fastest, then page column, page row and tile. Each page is a tile with
// border_size pixels added on every side; source coordinates clamp to the image
// edge so the border repeats the edge pixels. A word with restart set starts over
// at the first element and returns it; after the element flagged last_in_image the
// block returns nothing until a restart. Each element goes through fetch and advance
// the counters, the row-times-width multiply and the output register load, in that
// order; the next word is taken in the cycle the output register loads, so no word
// is taken before the last one reaches it, and a word that finds the block finished
// is dropped without an element. The output register holds a word while the far side
// stalls without blocking the next word's fetch and multiply. The user must write the
// registers only while no word is in flight; the block itself does not enforce it.
// A register index beyond the map is ignored.
module tile_page_address_generator #(
  parameter int MAX_DIM      = tpag_pkg::MAX_DIM_DEF,
  parameter int MAX_TILE     = tpag_pkg::MAX_TILE_DEF,
  parameter int MAX_BORDER   = tpag_pkg::MAX_BORDER_DEF,
  parameter int MAX_CHANNELS = tpag_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register write port
  input  logic                              cfg_we_i,
  input  logic [tpag_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // step request word
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  // element word
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tpag_pkg::SRC_IDX_W-1:0]    source_index_o,
  output logic [tpag_pkg::PAGE_ELEM_W-1:0]  page_element_o,
  output logic [tpag_pkg::PAGE_BYTE_W-1:0]  page_byte_offset_o,
  output logic [tpag_pkg::TILE_NUM_W-1:0]   tile_number_o,
  output logic                              last_in_tile_o,
  output logic                              last_in_image_o
);

  tpag_pkg::cfg_t cfg;
  tpag_pkg::cmd_t cmd;
  tpag_pkg::sts_t sts;

  // raw register values, limits applied in the datapath
  tpag_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // step sequencer, owns the input handshake
  tpag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, clamp, index arithmetic and the output register
  tpag_datapath #(
    .MAX_DIM      (MAX_DIM),
    .MAX_TILE     (MAX_TILE),
    .MAX_BORDER   (MAX_BORDER),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .restart_i          (restart_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .source_index_o     (source_index_o),
    .page_element_o     (page_element_o),
    .page_byte_offset_o (page_byte_offset_o),
    .tile_number_o      (tile_number_o),
    .last_in_tile_o     (last_in_tile_o),
    .last_in_image_o    (last_in_image_o)
  );

endmodule

/* sv/tpag_checker.sv */
// port-level checks of the tile page address generator and their bind
// depends on tpag_pkg and tile_page_address_generator
module tpag_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [tpag_pkg::SRC_IDX_W-1:0]    source_index_o,
  input logic [tpag_pkg::PAGE_ELEM_W-1:0]  page_element_o,
  input logic [tpag_pkg::PAGE_BYTE_W-1:0]  page_byte_offset_o,
  input logic [tpag_pkg::TILE_NUM_W-1:0]   tile_number_o,
  input logic                              last_in_tile_o,
  input logic                              last_in_image_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // a stalled element word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(source_index_o) &&
      $stable(page_element_o) && $stable(page_byte_offset_o) &&
      $stable(tile_number_o) && $stable(last_in_tile_o) && $stable(last_in_image_o))
    else $error("stalled element word changed");

  // the last element of the image also ends its page
  a_last_nest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_in_image_o |-> last_in_tile_o)
    else $error("last_in_image without last_in_tile");

  // one word in flight: a taken word is followed by a fetch cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o)
    else $error("second word taken during fetch");

  // a taken word reaches an empty output register after fetch, multiply and emit
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_take, 4))
    else $error("element word without a matching step word");

endmodule

bind tile_page_address_generator tpag_checker u_tpag_checker (.*);

/* sim/tile_page_address_generator_tb.sv */
// self-checking testbench of the tile page address generator
// directed table then random traversals, checked against typed values or a predictor
// depends on tpag_pkg and tile_page_address_generator
module tile_page_address_generator_tb;
  import tpag_pkg::*;

  // register indexes outside the map and the sample format that has no name
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic [1:0]            FMT_UNUSED    = 2'd3;

  localparam int WORD_TARGET    = 620;   // random step words, the directed table adds a few
  localparam int SETTLE_CYCLES  = 8;     // longest in-flight time of a word, with margin
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [SRC_IDX_W-1:0]   source_index;
    logic [PAGE_ELEM_W-1:0] page_element;
    logic [PAGE_BYTE_W-1:0] page_byte_offset;
    logic [TILE_NUM_W-1:0]  tile_number;
    logic                   last_in_tile;
    logic                   last_in_image;
  } element_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_STEP} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_ADDR_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0]  wdata;
    logic                   restart;
    row_check_e             chk;
    element_t               want;
  } stim_row_t;

  localparam element_t NO_ELEM = '0;
  localparam int DIRECTED_ROWS = 39;

  // directed part: typed results only where they are obvious, the rest go to the predictor
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // idle straight out of reset
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_NONE,  NO_ELEM},
    // 1x1 image, single element flagged last of tile and image
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b1, CHK_TYPED, '{30'd0, 23'd0, 25'd0, 28'd0, 1'b1, 1'b1}},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_NONE,  NO_ELEM},
    // writes beyond the map change nothing
    '{ROW_WRITE, REG_UNUSED_LO,     15'h7fff,  1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_UNUSED_HI,     15'h7fff,  1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b1, CHK_TYPED, '{30'd0, 23'd0, 25'd0, 28'd0, 1'b1, 1'b1}},
    // width saturates, zero height and tile taken as one
    '{ROW_WRITE, REG_IMAGE_WIDTH,   15'h7fff,  1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_IMAGE_HEIGHT,  15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_TILE_SIZE,     15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b1, CHK_TYPED, '{30'd0, 23'd0, 25'd0, 28'd0, 1'b1, 1'b0}},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_TYPED, '{30'd1, 23'd0, 25'd0, 28'd1, 1'b1, 1'b0}},
    // border, channels and format above range, written mid traversal
    '{ROW_WRITE, REG_BORDER_SIZE,   15'd127,   1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 15'd7,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_SAMPLE_FORMAT, 15'(FMT_UNUSED), 1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b1, CHK_TYPED, '{30'd0, 23'd0, 25'd0, 28'd0, 1'b0, 1'b0}},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_TYPED, '{30'd1, 23'd1, 25'd4, 28'd0, 1'b0, 1'b0}},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_TILE_SIZE,     15'h7ff,   1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_IMAGE_HEIGHT,  15'd16384, 1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_SAMPLE_FORMAT, 15'(FMT_U16), 1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_SAMPLE_FORMAT, 15'(FMT_F32), 1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    // 3x2 image in 2x2 tiles: one full tile, one partial on the right
    '{ROW_WRITE, REG_IMAGE_WIDTH,   15'd3,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_IMAGE_HEIGHT,  15'd2,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_TILE_SIZE,     15'd2,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_BORDER_SIZE,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_CHANNEL_COUNT, 15'd1,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_WRITE, REG_SAMPLE_FORMAT, 15'(FMT_U8), 1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b1, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_MODEL, NO_ELEM},
    // last element of the image, then idle again
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_TYPED, '{30'd5, 23'd1, 25'd1, 28'd1, 1'b1, 1'b1}},
    '{ROW_STEP,  REG_IMAGE_WIDTH,   15'd0,     1'b0, CHK_NONE,  NO_ELEM}
  };

  // dut inputs, all known from time zero
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   restart_i   = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [SRC_IDX_W-1:0]   source_index_o;
  logic [PAGE_ELEM_W-1:0] page_element_o;
  logic [PAGE_BYTE_W-1:0] page_byte_offset_o;
  logic [TILE_NUM_W-1:0]  tile_number_o;
  logic                   last_in_tile_o;
  logic                   last_in_image_o;

  tile_page_address_generator DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .restart_i          (restart_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .source_index_o     (source_index_o),
    .page_element_o     (page_element_o),
    .page_byte_offset_o (page_byte_offset_o),
    .tile_number_o      (tile_number_o),
    .last_in_tile_o     (last_in_tile_o),
    .last_in_image_o    (last_in_image_o)
  );

  always #5 clk_i = ~clk_i;

  // elements still owed by the dut, oldest first
  element_t expected_elements[$];
  element_t oldest_element;
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  int       send_idle_pct  = 0;
  int       stall_pct      = 0;

  // shadow registers and traversal position of the predictor
  cfg_t                   shadow_cfg;
  longint unsigned        trav_org_x, trav_org_y, trav_px, trav_py, trav_chan;
  logic [TILE_NUM_W-1:0]  trav_tile;
  logic [PAGE_ELEM_W-1:0] trav_elem;
  bit                     trav_done;

  function automatic longint unsigned clip(longint unsigned v, longint unsigned lo,
                                           longint unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // tile width or height; an origin past the image edge still gives one pixel
  function automatic longint unsigned tile_span(longint unsigned origin, longint unsigned dim,
                                                longint unsigned ts);
    if (origin >= dim) return 1;
    return (dim - origin < ts) ? dim - origin : ts;
  endfunction

  // page position back to a source coordinate, clamped to the image edge
  function automatic longint unsigned image_coord(longint unsigned origin, longint unsigned pos,
                                                  longint unsigned bs, longint unsigned dim);
    longint unsigned s;
    s = origin + pos;
    if (s < bs) return 0;
    s -= bs;
    return (s > dim - 1) ? dim - 1 : s;
  endfunction

  function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH:   shadow_cfg.image_width   = val[14:0];
      REG_IMAGE_HEIGHT:  shadow_cfg.image_height  = val[14:0];
      REG_TILE_SIZE:     shadow_cfg.tile_size     = val[10:0];
      REG_BORDER_SIZE:   shadow_cfg.border_size   = val[6:0];
      REG_CHANNEL_COUNT: shadow_cfg.channel_count = val[2:0];
      REG_SAMPLE_FORMAT: shadow_cfg.sample_format = val[1:0];
      default: ;
    endcase
  endfunction

  // one accepted step word; returns 1 and the element when the word yields one
  function automatic bit predict_step(logic rs, output element_t elem);
    longint unsigned w, h, ts, bs, nc, nbytes, pw, ph, sx, sy;
    bit end_c, end_x, end_y, last_tile;
    elem = '0;
    w  = clip(shadow_cfg.image_width, 1, MAX_DIM_DEF);
    h  = clip(shadow_cfg.image_height, 1, MAX_DIM_DEF);
    ts = clip(shadow_cfg.tile_size, 1, MAX_TILE_DEF);
    bs = clip(shadow_cfg.border_size, 0, MAX_BORDER_DEF);
    nc = clip(shadow_cfg.channel_count, 1, MAX_CHANNELS_DEF);
    nbytes = (shadow_cfg.sample_format == FMT_U8) ? 1 :
             (shadow_cfg.sample_format == FMT_U16) ? 2 : 4;
    if (rs) begin
      trav_org_x = 0;
      trav_org_y = 0;
      trav_px    = 0;
      trav_py    = 0;
      trav_chan  = 0;
      trav_tile  = '0;
      trav_elem  = '0;
      trav_done  = 1'b0;
    end
    if (trav_done) return 1'b0;

    pw = tile_span(trav_org_x, w, ts) + 2 * bs;
    ph = tile_span(trav_org_y, h, ts) + 2 * bs;
    sx = image_coord(trav_org_x, trav_px, bs, w);
    sy = image_coord(trav_org_y, trav_py, bs, h);
    end_c = (trav_chan + 1 >= nc);
    end_x = (trav_px + 1 >= pw);
    end_y = (trav_py + 1 >= ph);
    last_tile = (trav_org_x + ts >= w) && (trav_org_y + ts >= h);

    elem.source_index     = SRC_IDX_W'((sy * w + sx) * nc + trav_chan);
    elem.page_element     = trav_elem;
    elem.page_byte_offset = PAGE_BYTE_W'(trav_elem * nbytes);
    elem.tile_number      = trav_tile;
    elem.last_in_tile     = end_c && end_x && end_y;
    elem.last_in_image    = end_c && end_x && end_y && last_tile;

    // channel fastest, then column, row, tile
    trav_elem = trav_elem + 1'b1;
    if (!end_c) begin
      trav_chan++;
      return 1'b1;
    end
    trav_chan = 0;
    if (!end_x) begin
      trav_px++;
      return 1'b1;
    end
    trav_px = 0;
    if (!end_y) begin
      trav_py++;
      return 1'b1;
    end
    trav_py   = 0;
    trav_elem = '0;
    trav_tile = trav_tile + 1'b1;
    if (trav_org_x + ts < w) begin
      trav_org_x += ts;
      return 1'b1;
    end
    trav_org_x = 0;
    if (trav_org_y + ts < h) begin
      trav_org_y += ts;
      return 1'b1;
    end
    trav_org_y = 0;
    trav_done  = 1'b1;
    return 1'b1;
  endfunction

  // idle odds follow the progress of the run: sender light, then receiver light, then none
  function automatic void set_idling(int done_words);
    if (done_words < WORD_TARGET / 3) begin
      send_idle_pct = 23;
      stall_pct     = 57;
    end else if (done_words < 2 * WORD_TARGET / 3) begin
      send_idle_pct = 57;
      stall_pct     = 23;
    end else begin
      send_idle_pct = 0;
      stall_pct     = 0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // present one step word and hold it until accepted; valid stays up for the caller
  task automatic send_step(input logic rs);
    cfg_we_i <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // nothing in flight: all owed elements back, and time for a dropped word to clear
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (expected_elements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write enable is left high so back-to-back writes need one assignment per edge
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // compare every accepted element with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_elements.size() == 0) begin
        report_mismatch("element with nothing expected");
      end else begin
        oldest_element = expected_elements.pop_front();
        check_field("source_index", source_index_o, oldest_element.source_index);
        check_field("page_element", page_element_o, oldest_element.page_element);
        check_field("page_byte_offset", page_byte_offset_o, oldest_element.page_byte_offset);
        check_field("tile_number", tile_number_o, oldest_element.tile_number);
        check_field("last_in_tile", last_in_tile_o, oldest_element.last_in_tile);
        check_field("last_in_image", last_in_image_o, oldest_element.last_in_image);
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    element_t elem;
    bit       produced;
    bit       prev_step;
    logic     rs;
    int       random_words;
    int       burst;
    int       setup_kind;

    shadow_cfg = '{image_width: 15'd1, image_height: 15'd1, tile_size: 11'd1,
                   border_size: 7'd0, channel_count: 3'd1, sample_format: 2'd0};
    trav_org_x = 0;
    trav_org_y = 0;
    trav_px    = 0;
    trav_py    = 0;
    trav_chan  = 0;
    trav_tile  = '0;
    trav_elem  = '0;
    trav_done  = 1'b1;
    prev_step  = 1'b0;
    random_words = 0;
    set_idling(0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        if (prev_step) wait_quiet();
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].wdata);
        prev_step = 1'b0;
      end else begin
        send_step(DIRECTED[r].restart);
        produced = predict_step(DIRECTED[r].restart, elem);
        case (DIRECTED[r].chk)
          CHK_MODEL: if (produced) expected_elements.push_back(elem);
          CHK_TYPED: expected_elements.push_back(DIRECTED[r].want);
          default: ;
        endcase
        prev_step = 1'b1;
      end
    end

    // random traversals, each burst under a fresh register setup
    while (random_words < WORD_TARGET) begin
      wait_quiet();
      setup_kind = $urandom_range(0, 9);
      if (setup_kind == 0) begin
        // anything the port can carry, out of range values included
        write_reg(REG_IMAGE_WIDTH,   CFG_DATA_W'($urandom_range(0, 32767)));
        write_reg(REG_IMAGE_HEIGHT,  CFG_DATA_W'($urandom_range(0, 32767)));
        write_reg(REG_TILE_SIZE,     CFG_DATA_W'($urandom_range(0, 32767)));
        write_reg(REG_BORDER_SIZE,   CFG_DATA_W'($urandom_range(0, 32767)));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 32767)));
        write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'($urandom_range(0, 32767)));
      end else if (setup_kind < 4) begin
        // tiny images so traversals finish and idle words follow
        write_reg(REG_IMAGE_WIDTH,   CFG_DATA_W'($urandom_range(1, 3)));
        write_reg(REG_IMAGE_HEIGHT,  CFG_DATA_W'($urandom_range(1, 3)));
        write_reg(REG_TILE_SIZE,     CFG_DATA_W'($urandom_range(1, 3)));
        write_reg(REG_BORDER_SIZE,   CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(1, 2)));
        write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'($urandom_range(0, 3)));
      end else begin
        write_reg(REG_IMAGE_WIDTH,   CFG_DATA_W'($urandom_range(1, 12)));
        write_reg(REG_IMAGE_HEIGHT,  CFG_DATA_W'($urandom_range(1, 12)));
        write_reg(REG_TILE_SIZE,     CFG_DATA_W'($urandom_range(1, 6)));
        write_reg(REG_BORDER_SIZE,   CFG_DATA_W'($urandom_range(0, 2)));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(1, 4)));
        write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                  CFG_DATA_W'($urandom_range(0, 32767)));

      // most bursts start clean; the rest carry on under the new registers
      burst = $urandom_range(20, 80);
      for (int i = 0; i < burst; i++) begin
        rs = (i == 0 && $urandom_range(0, 3) != 0) ||
             (trav_done && $urandom_range(0, 2) == 0) ||
             ($urandom_range(0, 59) == 0);
        set_idling(random_words);
        send_step(rs);
        random_words++;
        produced = predict_step(rs, elem);
        if (produced) expected_elements.push_back(elem);
      end
    end

    wait_quiet();
    if (mismatch_count == 0 && expected_elements.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
